/* hw/rtl/wacc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the warp access coalescing counter.
// No dependencies; every other file of the block imports this package.
package wacc_pkg;

    localparam int ADDR_W      = 64;
    localparam int WS_W        = 11;
    localparam int TOTAL_W     = 32;
    localparam int WS_RESET    = 32;
    localparam int WORD_BYTES  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W   = 72;   // lane_active, lane_address, zero fill
    localparam int IN_USER_W   = 3;    // is_store, is_global, word_sized
    localparam int OUT_DATA_W  = 136;  // two flags, four totals, zero fill

    // One classified lane as it travels from the front part to the back part.
    typedef struct packed {
        logic              active;
        logic [ADDR_W-1:0] seg;
        logic              store;
        logic              global_sp;
        logic              word;
        logic              last;
    } t_lane;

endpackage

/* hw/rtl/wacc_front.sv */
`timescale 1ns / 1ps
// Front part: unpacks an incoming lane and masks its address down to its segment.
// Depends on wacc_pkg.
module wacc_front #(
    parameter int MAX_WARP_SIZE = 1024
) (
    input  logic [wacc_pkg::WS_W-1:0]      i_warp_size,
    input  logic [wacc_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic [wacc_pkg::IN_USER_W-1:0] i_tuser,
    input  logic                           i_tlast,
    output wacc_pkg::t_lane                o_lane
);
    import wacc_pkg::*;

    logic [ADDR_W-1:0] ws_eff;
    logic [ADDR_W-1:0] seg_mask;

    // A size of zero acts as one; sizes beyond the maximum are clamped.
    always_comb begin
        ws_eff = ADDR_W'(i_warp_size);
        if (ws_eff == '0) begin
            ws_eff = ADDR_W'(1);
        end else if (ws_eff > ADDR_W'(MAX_WARP_SIZE)) begin
            ws_eff = ADDR_W'(MAX_WARP_SIZE);
        end
        seg_mask = ~((ws_eff << $clog2(WORD_BYTES)) - ADDR_W'(1));
    end

    always_comb begin
        o_lane.active    = i_tdata[0];
        o_lane.seg       = i_tdata[ADDR_W:1] & seg_mask;
        o_lane.store     = i_tuser[0];
        o_lane.global_sp = i_tuser[1];
        o_lane.word      = i_tuser[2];
        o_lane.last      = i_tlast;
    end

endmodule

/* hw/rtl/wacc_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified lanes between the front and back parts.
// Depends on wacc_pkg.
module wacc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wacc_pkg::t_lane i_lane,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output wacc_pkg::t_lane o_lane
);
    import wacc_pkg::*;

    t_lane             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_lane  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_lane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/wacc_back.sv */
`timescale 1ns / 1ps
// Back part: per-warp segment tracking, saturating counters and the output register.
// Depends on wacc_pkg.
module wacc_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  wacc_pkg::t_lane                 i_lane,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [wacc_pkg::OUT_DATA_W-1:0] o_tdata
);
    import wacc_pkg::*;

    logic [ADDR_W-1:0]      r_base,  n_base;
    logic                   r_any,   n_any;
    logic                   r_miss,  n_miss;
    logic [COUNT_WIDTH-1:0] r_event, n_event;
    logic [COUNT_WIDTH-1:0] r_coal,  n_coal;
    logic [COUNT_WIDTH-1:0] r_load,  n_load;
    logic [COUNT_WIDTH-1:0] r_store, n_store;
    logic                   n_counted, n_coalesced;
    logic                   r_out_valid;
    logic                   r_counted, r_coalesced;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    assign o_pop = i_valid && (!r_out_valid || i_tready);

    always_comb begin
        n_base      = r_base;
        n_any       = r_any;
        n_miss      = r_miss;
        n_event     = r_event;
        n_coal      = r_coal;
        n_load      = r_load;
        n_store     = r_store;
        n_counted   = 1'b0;
        n_coalesced = 1'b0;
        if (i_lane.global_sp) begin
            if (i_lane.active) begin
                if (i_lane.store) begin
                    n_store = sat_inc(r_store);
                end else begin
                    n_load = sat_inc(r_load);
                end
                if (!r_any) begin
                    n_base = i_lane.seg;
                    n_any  = 1'b1;
                end else if (i_lane.seg != r_base) begin
                    n_miss = 1'b1;
                end
            end
            if (i_lane.last) begin
                if (n_any) begin
                    n_counted = 1'b1;
                    n_event   = sat_inc(r_event);
                    if (i_lane.word && !n_miss) begin
                        n_coalesced = 1'b1;
                        n_coal      = sat_inc(r_coal);
                    end
                end
                n_base = '0;
                n_any  = 1'b0;
                n_miss = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_any       <= 1'b0;
            r_miss      <= 1'b0;
            r_event     <= '0;
            r_coal      <= '0;
            r_load      <= '0;
            r_store     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_base  <= n_base;
                r_any   <= n_any;
                r_miss  <= n_miss;
                r_event <= n_event;
                r_coal  <= n_coal;
                r_load  <= n_load;
                r_store <= n_store;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_counted   <= n_counted;
            r_coalesced <= n_coalesced;
        end
    end

    // The counter registers hold the totals of the last result, so they feed tdata directly.
    assign o_tvalid = r_out_valid;
    assign o_tdata  = {6'b0,
                       TOTAL_W'(r_store), TOTAL_W'(r_load),
                       TOTAL_W'(r_coal),  TOTAL_W'(r_event),
                       r_coalesced, r_counted};

endmodule

/* hw/rtl/warp_access_coalescing_counter.sv */
`timescale 1ns / 1ps
// Top level of the warp access coalescing counter.
// Depends on wacc_pkg, wacc_front, wacc_queue and wacc_back.

// The block takes one thread lane of a warp's memory access per transaction
// and returns one result transaction per lane. Lanes outside global memory
// change nothing. Every active global lane bumps the load or store word
// counter; the lane marked by tlast closes the warp, which is counted as an
// event when any lane was active, and as coalesced too when the closing lane
// is word sized and every active lane's address, masked with
// ~(4*warp_size-1), fell into one segment. All counters saturate. Throughput
// is one lane per clock while results are taken without stalling. A lane
// accepted at the input is written into the two-entry queue and moves into
// the output register once that register is empty or its result is being
// taken; its result is then offered there. The queue decouples the two
// sides, so input keeps flowing while a result waits until the queue fills.
// warp_size resets to 32; the user must write it through i_cfg_we/i_cfg_wdata
// only while no transaction is in flight, as the block does not enforce it.
module warp_access_coalescing_counter #(
    parameter int MAX_WARP_SIZE = 1024,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wacc_pkg::WS_W-1:0]       i_cfg_wdata,    // warp_size
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] lane_active, [64:1] lane_address, [71:65] zero
    input  logic [wacc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] is_store, [1] is_global, [2] word_sized
    input  logic [wacc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                            s_axis_tlast,   // warp_last
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] warp_counted, [1] warp_coalesced, [33:2] event_total,
    // [65:34] coalesced_total, [97:66] loaded_total, [129:98] stored_total,
    // [135:130] zero
    output logic [wacc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import wacc_pkg::*;

    logic [WS_W-1:0] r_warp_size;
    t_lane           front_lane;
    t_lane           queue_lane;
    logic            queue_full;
    logic            queue_valid;
    logic            back_pop;
    logic            push;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warp_size <= WS_W'(WS_RESET);
        end else if (i_cfg_we) begin
            r_warp_size <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    wacc_front #(
        .MAX_WARP_SIZE(MAX_WARP_SIZE)
    ) u_front (
        .i_warp_size(r_warp_size),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_tlast    (s_axis_tlast),
        .o_lane     (front_lane)
    );

    wacc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_lane (front_lane),
        .o_full (queue_full),
        .i_pop  (back_pop),
        .o_valid(queue_valid),
        .o_lane (queue_lane)
    );

    wacc_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_lane  (queue_lane),
        .o_pop   (back_pop),
        .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready),
        .o_tdata (m_axis_tdata)
    );

    // A coalesced warp is always a counted warp.
    a_coal_implies_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
        else $error("coalesced flag without counted flag");

    // The coalesced total can never pass the warp event total.
    a_coal_le_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[65:34] <= m_axis_tdata[33:2]))
        else $error("coalesced total exceeds event total");

    // The back part only pops when the queue holds an entry.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> queue_valid)
        else $error("pop from empty queue");

    // Reset leaves the output side empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

/* tb/warp_access_coalescing_counter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the warp access coalescing counter.
// Depends on wacc_pkg and warp_access_coalescing_counter; needs nothing else.

// One lane as the testbench offers it to the block.
typedef struct packed {
    bit        active;
    bit [63:0] addr;
    bit        store;
    bit        is_global;
    bit        word;
    bit        last;
} t_lane_item;

// What one result transaction should carry.
typedef struct packed {
    bit        counted;
    bit        coalesced;
    bit [31:0] events;
    bit [31:0] coalesced_n;
    bit [31:0] loads;
    bit [31:0] stores;
} t_warp_totals;

// Tracks the per-warp segment state and the saturating counters, and keeps
// the totals that each accepted lane should produce, oldest first.
class coalesce_tally;
    localparam int unsigned WARP_CAP = 1024;

    bit [wacc_pkg::WS_W-1:0] warp_size;
    bit [63:0]               seg_base;
    bit                      any_active;
    bit                      split;
    bit [31:0]               events;
    bit [31:0]               coalesced_n;
    bit [31:0]               loads;
    bit [31:0]               stores;
    t_warp_totals            expected_totals[$];
    int unsigned             failures;

    function new();
        warp_size = wacc_pkg::WS_W'(wacc_pkg::WS_RESET);
    endfunction

    function int unsigned effective_size();
        int unsigned eff;
        eff = warp_size;
        if (eff == 0) eff = 1;
        if (eff > WARP_CAP) eff = WARP_CAP;
        return eff;
    endfunction

    function bit [31:0] bump(bit [31:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

    function int unsigned pending();
        return expected_totals.size();
    endfunction

    function void account_lane(t_lane_item it);
        t_warp_totals r;
        bit [63:0]    seg;
        r = '0;
        if (it.is_global) begin
            if (it.active) begin
                seg = it.addr & ~(64'(4 * effective_size()) - 64'd1);
                if (it.store) stores = bump(stores);
                else loads = bump(loads);
                if (!any_active) begin
                    seg_base   = seg;
                    any_active = 1'b1;
                end else if (seg != seg_base) begin
                    split = 1'b1;
                end
            end
            if (it.last) begin
                if (any_active) begin
                    r.counted = 1'b1;
                    events = bump(events);
                    if (it.word && !split) begin
                        r.coalesced = 1'b1;
                        coalesced_n = bump(coalesced_n);
                    end
                end
                seg_base   = '0;
                any_active = 1'b0;
                split      = 1'b0;
            end
        end
        r.events      = events;
        r.coalesced_n = coalesced_n;
        r.loads       = loads;
        r.stores      = stores;
        expected_totals.insert(expected_totals.size(), r);
    endfunction

    function void compare_totals(bit [wacc_pkg::OUT_DATA_W-1:0] d);
        t_warp_totals e;
        if (expected_totals.size() == 0) begin
            $error("result transaction with no lane waiting for it: %h", d);
            failures++;
            return;
        end
        e = expected_totals.pop_front();
        if (d[0] != e.counted) begin
            $error("warp_counted: expected %0d, got %0d", e.counted, d[0]);
            failures++;
        end
        if (d[1] != e.coalesced) begin
            $error("warp_coalesced: expected %0d, got %0d", e.coalesced, d[1]);
            failures++;
        end
        if (d[33:2] != e.events) begin
            $error("event_total: expected %0d, got %0d", e.events, d[33:2]);
            failures++;
        end
        if (d[65:34] != e.coalesced_n) begin
            $error("coalesced_total: expected %0d, got %0d", e.coalesced_n, d[65:34]);
            failures++;
        end
        if (d[97:66] != e.loads) begin
            $error("loaded_total: expected %0d, got %0d", e.loads, d[97:66]);
            failures++;
        end
        if (d[129:98] != e.stores) begin
            $error("stored_total: expected %0d, got %0d", e.stores, d[129:98]);
            failures++;
        end
    endfunction
endclass

module warp_access_coalescing_counter_tb;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [wacc_pkg::WS_W-1:0]       i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [0] lane_active, [64:1] lane_address, [71:65] zero
    logic [wacc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [0] is_store, [1] is_global, [2] word_sized
    logic [wacc_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [0] warp_counted, [1] warp_coalesced, [33:2] event_total,
    // [65:34] coalesced_total, [97:66] loaded_total, [129:98] stored_total
    logic [wacc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    coalesce_tally tally = new();

    // When set, both sides drop transactions at random about 9% of the time.
    bit gaps_on = 1'b1;
    // Asks the receiver to hold off for a long stretch so the block backs up.
    bit hold_req = 1'b0;

    warp_access_coalescing_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Generous ceiling, far beyond what the whole run needs.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver. It changes tready at the falling edge only. A hold-off request
    // turns into a tready stall counted down here, while the sender keeps going.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 249;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 9);
            end
        end
    end

    // Every result transaction is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tally.compare_totals(m_axis_tdata);
        end
    end

    function automatic t_lane_item mk(bit a, bit [63:0] ad, bit st, bit gl, bit wd,
                                      bit la);
        t_lane_item it;
        it.active    = a;
        it.addr      = ad;
        it.store     = st;
        it.is_global = gl;
        it.word      = wd;
        it.last      = la;
        return it;
    endfunction

    // Offers one lane. Entered and left at a falling edge; the prediction is
    // made at the rising edge where the transaction is accepted.
    task automatic send_lane(t_lane_item it);
        while (gaps_on && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, it.addr, it.active};
        s_axis_tuser  <= {it.word, it.is_global, it.store};
        s_axis_tlast  <= it.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tally.account_lane(it);
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tally.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The register is only written while the block holds no transaction.
    task automatic write_warp_size(bit [wacc_pkg::WS_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tally.warp_size = v;
    endtask

    // Random warps. Most lanes of a warp stay inside the first active lane's
    // segment so that coalesced warps are common; a few jump elsewhere, a few
    // are inactive or non-global, and some lanes are pure noise.
    task automatic drive_warps(int unsigned budget);
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        int unsigned span;
        bit [63:0]   base;
        bit          st;
        t_lane_item  it;
        sent = 0;
        span = 4 * tally.effective_size();
        while (sent < budget) begin
            if ($urandom_range(0, 99) < 12) begin
                it = mk($urandom_range(0, 1), {$urandom, $urandom}, $urandom_range(0, 1),
                        $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
                send_lane(it);
                if (it.is_global) sent++;
            end else begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                base = {$urandom, $urandom};
                st   = $urandom_range(0, 1);
                for (k = 0; k < len; k++) begin
                    it.active    = ($urandom_range(0, 99) < 85);
                    it.addr      = ($urandom_range(0, 99) < 8)
                                 ? {$urandom, $urandom}
                                 : base ^ 64'($urandom_range(0, span - 1));
                    it.store     = ($urandom_range(0, 19) == 0) ? !st : st;
                    it.is_global = ($urandom_range(0, 99) < 95);
                    it.word      = ($urandom_range(0, 99) < 85);
                    it.last      = (k == len - 1);
                    if (it.last) it.is_global = 1'b1;
                    send_lane(it);
                    if (it.is_global) sent++;
                end
            end
        end
    endtask

    initial begin
        t_lane_item              directed[$];
        bit [wacc_pkg::WS_W-1:0] sizes[9];
        int unsigned             p;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed lanes at the reset warp size of 32, so segments are 128 bytes.
        // Single-lane warps at both address extremes, a load and a store.
        directed.insert(directed.size(), mk(1, 64'h0, 0, 1, 1, 1));
        directed.insert(directed.size(), mk(1, '1, 1, 1, 1, 1));
        // Three lanes that stay inside one segment.
        directed.insert(directed.size(), mk(1, 64'h1000, 0, 1, 1, 0));
        directed.insert(directed.size(), mk(1, 64'h107C, 0, 1, 1, 0));
        directed.insert(directed.size(), mk(1, 64'h1040, 0, 1, 1, 1));
        // The second lane crosses into the next segment.
        directed.insert(directed.size(), mk(1, 64'h1000, 1, 1, 1, 0));
        directed.insert(directed.size(), mk(1, 64'h1080, 1, 1, 1, 1));
        // A warp with no active lane counts nothing.
        directed.insert(directed.size(), mk(0, 64'h40, 0, 1, 1, 0));
        directed.insert(directed.size(), mk(0, 64'h8000, 0, 1, 1, 1));
        // A non-global lane is ignored even with its closing flag set, so the
        // warp stays open and the far address does not split it.
        directed.insert(directed.size(), mk(1, 64'h2000, 0, 1, 1, 0));
        directed.insert(directed.size(), mk(1, 64'hDEAD_0000, 0, 0, 1, 1));
        directed.insert(directed.size(), mk(1, 64'h2004, 1, 1, 1, 1));
        // A closing lane that is not word sized skips the coalescing test.
        directed.insert(directed.size(), mk(1, 64'h3000, 0, 1, 1, 0));
        directed.insert(directed.size(), mk(1, 64'h3010, 0, 1, 0, 1));
        // An inactive lane far away leaves the segment intact.
        directed.insert(directed.size(), mk(1, 64'h4000, 1, 1, 1, 0));
        directed.insert(directed.size(), mk(0, '1, 1, 1, 1, 0));
        directed.insert(directed.size(), mk(1, 64'h4008, 1, 1, 1, 1));
        // The first active lane, not the first lane, sets the segment.
        directed.insert(directed.size(), mk(0, 64'h5000, 0, 1, 1, 0));
        directed.insert(directed.size(), mk(1, 64'h9000, 0, 1, 1, 0));
        directed.insert(directed.size(), mk(1, 64'h9010, 0, 1, 1, 1));
        // An inactive closing lane still counts a warp that had active lanes.
        directed.insert(directed.size(), mk(1, 64'hA000, 0, 1, 1, 0));
        directed.insert(directed.size(), mk(0, 64'hFFFF_0000, 0, 1, 1, 1));
        // A lone non-global lane.
        directed.insert(directed.size(), mk(0, 64'h0, 0, 0, 0, 0));
        foreach (directed[i]) send_lane(directed[i]);
        drain();

        // Zero acts as one, 2047 is clamped to the cap, 3 and 100 are not
        // powers of two and give odd masks.
        sizes[0] = 11'd0;
        sizes[1] = 11'd1;
        sizes[2] = 11'd2047;
        sizes[3] = 11'd1024;
        sizes[4] = 11'd3;
        sizes[5] = 11'd100;
        sizes[6] = 11'd32;
        sizes[7] = 11'($urandom_range(0, 2047));
        sizes[8] = 11'($urandom_range(1, 64));

        for (p = 0; p < 9; p++) begin
            write_warp_size(sizes[p]);
            // One phase runs with no idling on either side, and one starts with
            // a long receiver stall so the queue fills and tready drops.
            gaps_on = (p != 2);
            if (p == 4) hold_req = 1'b1;
            drive_warps(92);
            drain();
        end
        gaps_on = 1'b1;

        // Give a stray extra result time to show up.
        repeat (8) @(posedge i_clk);
        if (tally.failures == 0 && tally.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
